>>> rtl/wmd_pkg.sv
// Shared constants and types for the windowed mean and deviation channel.
`default_nettype none
package wmd_pkg;
  localparam int WIN_DEPTH = 64;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEPTH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_FF     = 3'd2;
  localparam logic [IDX_W-1:0] REG_NORM   = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAIN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_SHIFT  = 3'd5;
  localparam logic [IDX_W-1:0] REG_LIM_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_LIM_HI = 3'd7;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_MEAN   = 2'd1;
  localparam logic [1:0] MODE_DELTA  = 2'd2;
  localparam logic [1:0] MODE_FORGET = 2'd3;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic clear;
    logic push;
    logic setup;
    logic rd;
    logic mul;
    logic acc;
    logic div_start;
    logic fmul;
    logic vset;
    logic vsq;
    logic sqrt_start;
    logic dclamp;
    logic scale;
    logic fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic simple;
    logic last;
    logic forget;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

>>> rtl/wmd_if.sv
// Channel interfaces: request, result and configuration write.
`default_nettype none
interface wmd_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] sample;
  modport source(output valid, req_type, sample, input ready);
  modport sink(input valid, req_type, sample, output ready);
endinterface

interface wmd_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mean_value;
  logic signed [31:0] deviation;
  logic               data_ready;
  modport source(output valid, mean_value, deviation, data_ready, input ready);
  modport sink(input valid, mean_value, deviation, data_ready, output ready);
endinterface

interface wmd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [wmd_pkg::IDX_W-1:0]  index;
  logic [31:0]                data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/wmd_div.sv
// Two-lane restoring divider sharing one narrow divisor, one quotient bit per cycle.
`default_nettype none
module wmd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [wmd_pkg::CNT_W-1:0] divisor,
  input  logic [63:0]               dvd_a,
  input  logic [63:0]               dvd_b,
  output logic [63:0]               quo_a,
  output logic [63:0]               quo_b,
  output logic                      done
);
  localparam int DW  = 64;
  localparam int CW  = $clog2(DW);
  localparam int RW  = wmd_pkg::CNT_W;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [RW-1:0] ra, rb;
  logic [RW:0]   ta, tb;
  logic          ga, gb;
  logic [RW:0]   ta_sub, tb_sub;

  always_comb begin
    ta     = {ra, quo_a[DW-1]};
    tb     = {rb, quo_b[DW-1]};
    ga     = ta >= {1'b0, divisor};
    gb     = tb >= {1'b0, divisor};
    ta_sub = ta - {1'b0, divisor};
    tb_sub = tb - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_a <= dvd_a;
      quo_b <= dvd_b;
      ra    <= '0;
      rb    <= '0;
    end else if (busy) begin
      quo_a <= {quo_a[DW-2:0], ga};
      quo_b <= {quo_b[DW-2:0], gb};
      ra    <= ga ? ta_sub[RW-1:0] : ta[RW-1:0];
      rb    <= gb ? tb_sub[RW-1:0] : tb[RW-1:0];
    end
  end
endmodule
`default_nettype wire

>>> rtl/wmd_sqrt.sv
// Bit-pair square root of a Q48.16 value into a Q24.16 root, one root bit per cycle.
`default_nettype none
module wmd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic [39:0] root,
  output logic        done
);
  localparam int STEPS = 40;
  localparam int CW    = $clog2(STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [79:0]   xs;
  logic [43:0]   rem;
  logic [43:0]   t, trial, t_sub;
  logic          ge;

  always_comb begin
    t     = {rem[41:0], xs[79:78]};
    trial = {2'b00, root, 2'b01};
    ge    = t >= trial;
    t_sub = t - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= {rad, 16'd0};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xs   <= {xs[77:0], 2'b00};
      rem  <= ge ? t_sub : t;
      root <= {root[38:0], ge};
    end
  end
endmodule
`default_nettype wire

>>> rtl/wmd_dp.sv
// Datapath: configuration registers, sample window, accumulators, scaling and output register.
`default_nettype none
module wmd_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  wmd_pkg::cmd_t             cmd,
  output wmd_pkg::stat_t            stat,
  input  logic signed [31:0]        sample,
  input  logic                      cfg_valid,
  input  logic [wmd_pkg::IDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  output logic                      cfg_ready,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic signed [31:0]        mean_value,
  output logic signed [31:0]        deviation,
  output logic                      data_ready
);
  localparam int AW = wmd_pkg::WIN_AW;
  localparam int CW = wmd_pkg::CNT_W;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t scale_sat(input logic signed [63:0] p,
                                     input logic signed [31:0] off);
    logic signed [47:0] q;
    logic signed [48:0] t;
    sat_t               r;
    q = p[63:16];
    if (p[63] && (p[15:0] != 16'd0)) q = q + 48'sd1;
    t = {q[47], q} + {{17{off[31]}}, off};
    if ((t[48:31] != '0) && (t[48:31] != '1)) begin
      r.ovf = 1'b1;
      r.val = t[48] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r.ovf = 1'b0;
      r.val = t[31:0];
    end
    return r;
  endfunction

  logic [1:0]         mode;
  logic [6:0]         depth;
  logic [15:0]        ff;
  logic [31:0]        norm;
  logic signed [31:0] gain, shift, lim_lo, lim_hi;

  logic [31:0]        mem [wmd_pkg::WIN_DEPTH];
  logic [AW-1:0]      head, idx, head_p1, rd_addr;
  logic [CW-1:0]      fill, m, d_eff, m_cur;
  logic               parity, neg;
  logic signed [31:0] samp_r, rd, prev;
  logic signed [63:0] sum;
  logic [63:0]        sq;
  logic [16:0]        wt;
  logic signed [32:0] y, y_c, y_abs;
  logic [31:0]        a;
  logic [63:0]        sqa;
  logic signed [49:0] ywt;
  logic [63:0]        p_v, p_h;
  logic [47:0]        p_l;
  logic signed [31:0] v_c, dev_c;
  logic               ovf_v, ovf_d;
  logic [63:0]        msq, sq_v;
  logic signed [63:0] pm, pd;
  logic signed [31:0] mv_r, dv_r;
  logic               rdy_r;

  logic               simple, skip, is_delta, is_forget;
  logic [47:0]        sq16;
  logic [63:0]        sqw, term_sq;
  logic signed [63:0] term_sum, ysx;
  logic [32:0]        wt_mul;
  logic [63:0]        sum_mag, dvd_a, dvd_b, quo_a, quo_b, vmag, rad;
  logic [CW-1:0]      divisor;
  logic               vneg;
  logic [31:0]        vabs;
  logic [63:0]        vsq_full;
  logic [39:0]        root;
  logic               div_done, sqrt_done;
  sat_t               sm, sd;

  assign cfg_ready = 1'b1;
  assign head_p1   = head + AW'(1);
  assign rd_addr   = head - idx;
  assign is_delta  = mode == wmd_pkg::MODE_DELTA;
  assign is_forget = mode == wmd_pkg::MODE_FORGET;

  always_comb begin
    if (depth == 7'd0) d_eff = CW'(1);
    else if (depth > 7'(wmd_pkg::WIN_DEPTH)) d_eff = CW'(wmd_pkg::WIN_DEPTH);
    else d_eff = CW'(depth);
    m_cur  = (fill < d_eff) ? fill : d_eff;
    simple = (mode == wmd_pkg::MODE_NONE) || (m_cur == CW'(1));

    y_c   = is_delta ? ({rd[31], rd} - {prev[31], prev}) : {rd[31], rd};
    y_abs = y_c[32] ? -y_c : y_c;
    a     = y_abs[31:0];

    sq16     = sqa[63:16];
    sqw      = sq16 * wt;
    term_sq  = is_forget ? sqw : {16'd0, sq16};
    ysx      = {{31{y[32]}}, y};
    case (mode)
      wmd_pkg::MODE_DELTA:  term_sum = neg ? -ysx : ysx;
      wmd_pkg::MODE_FORGET: term_sum = {{14{ywt[49]}}, ywt};
      default:              term_sum = {{32{rd[31]}}, rd};
    endcase
    skip   = is_delta && (idx == '0);
    wt_mul = wt * ff;

    sum_mag = sum[63] ? 64'(-sum) : 64'(sum);
    dvd_a   = is_delta ? (sum_mag >> 1) : sum_mag;
    dvd_b   = is_delta ? (sq >> 2) : sq;
    divisor = is_delta ? (m - CW'(1)) : m;

    vmag     = is_forget ? {16'd0, p_v[63:16]} : quo_a;
    vneg     = sum[63];
    vabs     = v_c[31] ? 32'(-v_c) : 32'(v_c);
    vsq_full = vabs * vabs;
    rad      = (msq > sq_v) ? (msq - sq_v) : 64'd0;

    sm = scale_sat(pm, shift);
    sd = scale_sat(pd, shift);
  end

  always_comb begin
    stat.simple    = simple;
    stat.last      = CW'(idx) == (m - CW'(1));
    stat.forget    = is_forget;
    stat.div_done  = div_done;
    stat.sqrt_done = sqrt_done;
    stat.out_free  = !res_valid || res_ready;
  end

  wmd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .divisor (divisor),
    .dvd_a   (dvd_a),
    .dvd_b   (dvd_b),
    .quo_a   (quo_a),
    .quo_b   (quo_b),
    .done    (div_done)
  );

  wmd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .rad   (rad),
    .root  (root),
    .done  (sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.push) mem[head_p1] <= sample;
    if (cmd.rd) rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= wmd_pkg::MODE_NONE;
      depth  <= 7'd1;
      ff     <= 16'd64881;
      norm   <= 32'd6553600;
      gain   <= 32'sd65536;
      shift  <= 32'sd0;
      lim_lo <= 32'sh8000_0000;
      lim_hi <= 32'sh7fff_ffff;
    end else if (cfg_valid) begin
      case (cfg_index)
        wmd_pkg::REG_MODE:   mode   <= cfg_data[1:0];
        wmd_pkg::REG_DEPTH:  depth  <= cfg_data[6:0];
        wmd_pkg::REG_FF:     ff     <= cfg_data[15:0];
        wmd_pkg::REG_NORM:   norm   <= cfg_data;
        wmd_pkg::REG_GAIN:   gain   <= cfg_data;
        wmd_pkg::REG_SHIFT:  shift  <= cfg_data;
        wmd_pkg::REG_LIM_LO: lim_lo <= cfg_data;
        wmd_pkg::REG_LIM_HI: lim_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      parity    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        fill   <= '0;
        parity <= 1'b0;
      end else if (cmd.push) begin
        head   <= head_p1;
        fill   <= (fill < CW'(wmd_pkg::WIN_DEPTH)) ? fill + CW'(1) : fill;
        parity <= ~parity;
      end
      if (cmd.load_out) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) samp_r <= sample;
    if (cmd.clear) begin
      mv_r  <= '0;
      dv_r  <= '0;
      rdy_r <= 1'b0;
    end
    if (cmd.setup) begin
      m   <= m_cur;
      idx <= '0;
      sum <= '0;
      sq  <= '0;
      wt  <= 17'h1_0000 - {1'b0, ff};
      neg <= parity;
      if (simple) begin
        v_c   <= samp_r;
        dev_c <= '0;
        ovf_v <= 1'b0;
        ovf_d <= 1'b0;
      end
    end
    if (cmd.mul) begin
      y    <= y_c;
      prev <= rd;
      sqa  <= a * a;
      ywt  <= rd * $signed({1'b0, wt});
    end
    if (cmd.acc) begin
      if (!skip) begin
        sum <= sum + term_sum;
        sq  <= sq + term_sq;
        if (is_delta) neg <= ~neg;
      end
      wt  <= wt_mul[32:16];
      idx <= idx + AW'(1);
    end
    if (cmd.fmul) begin
      p_v <= sum_mag[47:16] * norm;
      p_h <= sq[63:32] * norm;
      p_l <= sq[31:16] * norm;
    end
    if (cmd.vset) begin
      msq <= is_forget ? (p_h + {32'd0, p_l[47:16]}) : quo_b;
      if (!vneg && (vmag > 64'h7fff_ffff)) begin
        v_c   <= 32'sh7fff_ffff;
        ovf_v <= 1'b1;
      end else if (vneg && (vmag > 64'h8000_0000)) begin
        v_c   <= 32'sh8000_0000;
        ovf_v <= 1'b1;
      end else begin
        v_c   <= vneg ? 32'(-vmag) : 32'(vmag);
        ovf_v <= 1'b0;
      end
    end
    if (cmd.vsq) sq_v <= {16'd0, vsq_full[63:16]};
    if (cmd.dclamp) begin
      if (root > 40'h00_7fff_ffff) begin
        dev_c <= 32'sh7fff_ffff;
        ovf_d <= 1'b1;
      end else begin
        dev_c <= root[31:0];
        ovf_d <= 1'b0;
      end
    end
    if (cmd.scale) begin
      pm <= gain * v_c;
      pd <= gain * dev_c;
    end
    if (cmd.fin) begin
      mv_r  <= sm.val;
      dv_r  <= sd.val;
      rdy_r <= !(ovf_v || ovf_d || sm.ovf || sd.ovf) &&
               ($signed(sm.val) > lim_lo) && ($signed(sm.val) < lim_hi);
    end
    if (cmd.load_out) begin
      mean_value <= mv_r;
      deviation  <= dv_r;
      data_ready <= rdy_r;
    end
  end
endmodule
`default_nettype wire

>>> rtl/wmd_ctrl.sv
// Controller state machine sequencing the window walk, division, root and scaling.
`default_nettype none
module wmd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_type,
  output logic           req_ready,
  input  wmd_pkg::stat_t stat,
  output wmd_pkg::cmd_t  cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_DIVLD = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FMUL  = 4'd7;
  localparam logic [3:0] S_VSET  = 4'd8;
  localparam logic [3:0] S_VSQ   = 4'd9;
  localparam logic [3:0] S_SQL   = 4'd10;
  localparam logic [3:0] S_SQRT  = 4'd11;
  localparam logic [3:0] S_DCL   = 4'd12;
  localparam logic [3:0] S_SCALE = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0] state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = state == S_IDLE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_type == wmd_pkg::REQ_CLEAR) begin
            cmd.clear  = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.push   = 1'b1;
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = stat.simple ? S_SCALE : S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (stat.last) state_next = stat.forget ? S_FMUL : S_DIVLD;
        else state_next = S_RD;
      end
      S_DIVLD: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_VSET;
      end
      S_FMUL: begin
        cmd.fmul   = 1'b1;
        state_next = S_VSET;
      end
      S_VSET: begin
        cmd.vset   = 1'b1;
        state_next = S_VSQ;
      end
      S_VSQ: begin
        cmd.vsq    = 1'b1;
        state_next = S_SQL;
      end
      S_SQL: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQRT;
      end
      S_SQRT: begin
        if (stat.sqrt_done) state_next = S_DCL;
      end
      S_DCL: begin
        cmd.dclamp = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

>>> rtl/windowed_mean_and_deviation_channel_core.sv
// Top level of the windowed mean and deviation channel.
//
//   channel | direction | payload                                 | handshake
//   req     | in        | req_type, sample                        | valid/ready
//   res     | out       | mean_value, deviation, data_ready       | valid/ready
//   cfg     | in        | index, data                             | valid/ready
//
// A clear transaction goes straight to the output state and loads zeros into the result register once it is free.
// A push in mode none or with one filled entry skips the window walk; otherwise, for m averaged
// entries, running mean and alternating delta read each entry in turn through the single read
// port (read, multiply, accumulate) and then run the divider and the square root, while
// forgetting-factor mode skips the divider.
// Reset clears the fill count, parity and handshake state; the window is not cleared.
// A new request is taken while a finished result waits in the output register.
`default_nettype none
module windowed_mean_and_deviation_channel_core (
  input logic     clk,
  input logic     rst,
  wmd_req_if.sink   req,
  wmd_res_if.source res,
  wmd_cfg_if.sink   cfg
);
  wmd_pkg::cmd_t  cmd;
  wmd_pkg::stat_t stat;

  wmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wmd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .sample     (req.sample),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .cfg_ready  (cfg.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .mean_value (res.mean_value),
    .deviation  (res.deviation),
    .data_ready (res.data_ready)
  );
endmodule
`default_nettype wire

>>> rtl/wmd_checker.sv
// Port-level checks for the channel core and their bind.
`default_nettype none
module wmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] mean_value,
  input logic        data_ready
);
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request ready right after a transaction");

  a_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(req_ready))
    else $error("result loaded while idle");

  a_ready_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && data_ready |-> (mean_value != 32'h7fff_ffff) &&
                                (mean_value != 32'h8000_0000))
    else $error("ready result at a saturation value");
endmodule

bind windowed_mean_and_deviation_channel_core wmd_checker u_wmd_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .mean_value (res.mean_value),
  .data_ready (res.data_ready)
);
`default_nettype wire

>>> tb/sv/wmd_scoreboard.sv
// Prediction and checking of mean, deviation and ready flag for the channel core.
module wmd_scoreboard
  import wmd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  wmd_req_if   req,
  wmd_res_if   res,
  wmd_cfg_if   cfg,
  output int   errors,
  output int   pending
);
  typedef struct {
    logic signed [31:0] mean_value;
    logic signed [31:0] deviation;
    logic               data_ready;
  } stats_t;

  longint             window_q [WIN_DEPTH];
  int                 fill;
  bit                 parity;
  logic [1:0]         mode_r;
  logic [6:0]         depth_r;
  longint unsigned    ff_r;
  longint unsigned    norm_r;
  longint             gain_r;
  longint             shift_r;
  longint             lim_lo_r;
  longint             lim_hi_r;
  stats_t             expected_q[$];

  function automatic longint unsigned sq16(longint y);
    longint unsigned a;
    a = (y < 0) ? -y : y;
    return (a * a) >> 16;
  endfunction

  function automatic longint unsigned root_q16(longint unsigned x);
    longint unsigned rem, root, pair;
    rem = 0;
    root = 0;
    for (int k = 39; k >= 0; k--) begin
      pair = (k >= 8) ? ((x >> (2 * k - 16)) & 3) : 0;
      rem = (rem << 2) | pair;
      root = root << 1;
      if (rem >= ((root << 1) | 1)) begin
        rem = rem - ((root << 1) | 1);
        root = root | 1;
      end
    end
    return root;
  endfunction

  function automatic longint sat32(longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic stats_t compute_stats(logic kind, logic signed [31:0] smp);
    stats_t          r;
    bit              ovf;
    longint          v, dev, mv, dv, sum, sw, y, var_v, v16;
    longint unsigned sq, msq, wt;
    int              d, m;
    r = '{0, 0, 0};
    ovf = 0;
    v = 0;
    dev = 0;
    if (kind == REQ_CLEAR) begin
      fill = 0;
      parity = 0;
      return r;
    end
    for (int i = WIN_DEPTH - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = smp;
    if (fill < WIN_DEPTH) fill++;
    parity = ~parity;
    d = (depth_r == 0) ? 1 : int'(depth_r);
    if (d > WIN_DEPTH) d = WIN_DEPTH;
    m = (fill < d) ? fill : d;
    if (mode_r == MODE_NONE || m == 1) begin
      v = window_q[0];
    end else begin
      sum = 0;
      sq = 0;
      if (mode_r == MODE_MEAN) begin
        for (int i = 0; i < m; i++) begin
          sum += window_q[i];
          sq += sq16(window_q[i]);
        end
        v = sum / m;
        msq = sq / m;
      end else if (mode_r == MODE_DELTA) begin
        sw = parity ? -1 : 1;
        for (int i = 1; i < m; i++) begin
          y = window_q[i] - window_q[i-1];
          sum += sw * y;
          sq += sq16(y);
          sw = -sw;
        end
        v = sum / (2 * (m - 1));
        msq = sq / (4 * (m - 1));
      end else begin
        wt = 65536 - ff_r;
        for (int i = 0; i < m; i++) begin
          sum += window_q[i] * longint'(wt);
          sq += sq16(window_q[i]) * wt;
          wt = (wt * ff_r) >> 16;
        end
        v16 = sum / 65536;
        v = (v16 * longint'(norm_r)) / 65536;
        msq = ((sq >> 32) * norm_r) + ((((sq >> 16) & 64'hFFFF) * norm_r) >> 16);
      end
      v = sat32(v, ovf);
      var_v = longint'(msq) - longint'(sq16(v));
      dev = (var_v > 0) ? longint'(root_q16(var_v)) : 0;
      if (dev > 64'sd2147483647) begin
        dev = 64'sd2147483647;
        ovf = 1;
      end
    end
    mv = sat32((gain_r * v) / 65536 + shift_r, ovf);
    dv = sat32((gain_r * dev) / 65536 + shift_r, ovf);
    r.mean_value = mv[31:0];
    r.deviation  = dv[31:0];
    r.data_ready = !ovf && mv > lim_lo_r && mv < lim_hi_r;
    return r;
  endfunction

  always @(posedge clk) begin
    stats_t got, exp_r;
    if (rst) begin
      fill <= 0;
      parity <= 0;
      mode_r <= MODE_NONE;
      depth_r <= 7'd1;
      ff_r <= 64881;
      norm_r <= 6553600;
      gain_r <= 65536;
      shift_r <= 0;
      lim_lo_r <= -64'sd2147483648;
      lim_hi_r <= 64'sd2147483647;
      errors <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MODE:   mode_r <= cfg.data[1:0];
          REG_DEPTH:  depth_r <= cfg.data[6:0];
          REG_FF:     ff_r <= 64'(cfg.data[15:0]);
          REG_NORM:   norm_r <= 64'(cfg.data);
          REG_GAIN:   gain_r <= longint'(signed'(cfg.data));
          REG_SHIFT:  shift_r <= longint'(signed'(cfg.data));
          REG_LIM_LO: lim_lo_r <= longint'(signed'(cfg.data));
          REG_LIM_HI: lim_hi_r <= longint'(signed'(cfg.data));
          default: ;
        endcase
      end
      if (req.valid && req.ready) expected_q.push_back(compute_stats(req.req_type, req.sample));
      if (res.valid && res.ready) begin
        got = '{res.mean_value, res.deviation, res.data_ready};
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result transaction: mean %0d dev %0d rdy %0b",
                                    got.mean_value, got.deviation, got.data_ready);
          errors <= errors + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.mean_value !== exp_r.mean_value || got.deviation !== exp_r.deviation ||
              got.data_ready !== exp_r.data_ready) begin
            if (errors < 10)
              $display("mismatch: exp mean %0d dev %0d rdy %0b, got mean %0d dev %0d rdy %0b",
                       exp_r.mean_value, exp_r.deviation, exp_r.data_ready,
                       got.mean_value, got.deviation, got.data_ready);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

>>> tb/sv/tb_windowed_mean_and_deviation_channel_core.sv
// Stimulus, reset, clock and verdict for the windowed mean and deviation channel core.
module tb_windowed_mean_and_deviation_channel_core;
  import wmd_pkg::*;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   n_sent;
  bit   held;
  int   hold_left;

  wmd_req_if req();
  wmd_res_if res();
  wmd_cfg_if cfg();

  windowed_mean_and_deviation_channel_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg)
  );

  wmd_scoreboard u_scoreboard (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res     (res),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #50000000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stall pattern, one long hold-off once traffic is flowing.
  initial res.ready = 0;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 0;
    end else if (hold_left > 0) begin
      res.ready <= 0;
      hold_left <= hold_left - 1;
    end else if (!held && n_sent >= 300) begin
      held <= 1;
      hold_left <= 2500;
      res.ready <= 0;
    end else if (n_sent % 200 < 60) begin
      res.ready <= 1;
    end else begin
      res.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic reg_write(logic [IDX_W-1:0] idx, logic [31:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
    cfg.valid <= 0;
  endtask

  task automatic drain();
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] md, logic [6:0] dep, logic [15:0] ff, logic [31:0] nrm,
                           logic [31:0] gn, logic [31:0] sh, logic [31:0] lo, logic [31:0] hi);
    drain();
    reg_write(REG_MODE, {30'd0, md});
    reg_write(REG_DEPTH, {25'd0, dep});
    reg_write(REG_FF, {16'd0, ff});
    reg_write(REG_NORM, nrm);
    reg_write(REG_GAIN, gn);
    reg_write(REG_SHIFT, sh);
    reg_write(REG_LIM_LO, lo);
    reg_write(REG_LIM_HI, hi);
  endtask

  // Leaves valid high so back-to-back transactions need no toggle.
  task automatic send(logic kind, logic [31:0] smp);
    req.valid    <= 1;
    req.req_type <= kind;
    req.sample   <= smp;
    do @(negedge clk); while (!req.ready);
    @(posedge clk);
    n_sent++;
  endtask

  task automatic idle(int cycles);
    req.valid <= 0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [6:0] rand_depth();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
    endcase
  endfunction

  initial begin
    int burst, phase_items;
    rst = 1;
    n_sent = 0;
    held = 0;
    hold_left = 0;
    req.valid = 0;
    req.req_type = REQ_PUSH;
    req.sample = 0;
    cfg.valid = 0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(REQ_PUSH, 32'h7FFFFFFF);
    send(REQ_PUSH, 32'h80000000);
    idle(3);
    configure(MODE_MEAN, 7'd4, 16'd64881, 32'd6553600, 32'd65536, 32'd0,
              32'h80000000, 32'h7FFFFFFF);
    send(REQ_PUSH, 32'h7FFFFFFF);
    send(REQ_PUSH, 32'h7FFFFFFF);
    send(REQ_PUSH, 32'h80000000);
    send(REQ_PUSH, 32'hFFFFFFFF);
    send(REQ_CLEAR, 32'hFFFFFFFF);
    send(REQ_PUSH, 32'h00010000);
    idle(2);
    configure(MODE_DELTA, 7'd5, 16'd1, 32'd65536, 32'h7FFFFFFF, 32'h80000000,
              32'd100, 32'd0);
    send(REQ_PUSH, 32'h80000000);
    send(REQ_PUSH, 32'h7FFFFFFF);
    send(REQ_PUSH, 32'h80000000);
    send(REQ_PUSH, 32'h00000000);
    idle(1);
    configure(MODE_FORGET, 7'd127, 16'hFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h80000000, 32'h7FFFFFFF);
    send(REQ_PUSH, 32'h7FFFFFFF);
    send(REQ_PUSH, 32'h7FFFFFFF);
    send(REQ_PUSH, 32'h80000000);
    idle(1);
    configure(MODE_FORGET, 7'd0, 16'd64881, 32'd6553600, 32'd65536, 32'd0,
              32'h80000000, 32'h7FFFFFFF);
    send(REQ_PUSH, 32'h12345678);
    send(REQ_PUSH, 32'h00000001);
    idle(1);

    for (int phase = 0; phase < 9; phase++) begin
      configure(2'($urandom_range(0, 3)), rand_depth(),
                $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF)
                                          : 16'($urandom_range(1, 65535)),
                $urandom_range(0, 2) == 0 ? $urandom() : 32'($urandom_range(65536, 6553600)),
                rand_q16(), $urandom_range(0, 2) == 0 ? rand_q16() : 32'd0,
                $urandom_range(0, 2) == 0 ? $urandom() : 32'h80000000,
                $urandom_range(0, 2) == 0 ? $urandom() : 32'h7FFFFFFF);
      phase_items = 80;
      while (phase_items > 0) begin
        burst = $urandom_range(1, 12);
        for (int i = 0; i < burst && phase_items > 0; i++, phase_items--)
          send($urandom_range(0, 19) == 0 ? REQ_CLEAR : REQ_PUSH, rand_sample());
        if ($urandom_range(0, 15) == 0) begin
          idle(0);
          drain();
        end else if ($urandom_range(0, 2) != 0) begin
          idle($urandom_range(0, 40));
        end
      end
      idle(0);
    end

    drain();
    repeat (400) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
